[hw/rtl/dpfc_pkg.sv]
// ----------------------------------------------------------------------------
// dpfc_pkg
// Shared types and constants for the distinct prime factor counter.
// ----------------------------------------------------------------------------
package dpfc_pkg;

    localparam int COUNT_WIDTH   = 4;
    localparam int FIRST_DIVISOR = 2;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_TEST   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // take a new value, restart the search
        logic div_start;  // begin remainder / divisor
        logic div_step;   // one quotient bit
        logic hit_apply;  // divisor divided: keep quotient, count once
        logic advance;    // move to the next divisor
        logic publish;    // latch the final count
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic search_done;  // remainder <= 1 or divisor squared > remainder
        logic rem_zero;     // last division left no remainder
    } status_t;

endpackage

[hw/rtl/distinct_prime_factor_counter.sv]
// ----------------------------------------------------------------------------
// distinct_prime_factor_counter
// Counts the distinct primes that divide an unsigned integer by trial division.
// ----------------------------------------------------------------------------
// One value at a time. Divisors run upward from 2 until the divisor squared
// exceeds the remainder; every division goes through a one-bit-a-cycle
// restoring divider. Each divisor tried costs a square check, one quotient
// bit per cycle and a remainder test, and each further division by the same
// divisor costs the quotient bits and the test again. Small or smooth values
// therefore finish quickest; a large prime runs through every divisor up to
// its square root. A finished count sits in an output register, so the next
// value is taken while it waits. Zero yields 0.
module distinct_prime_factor_counter #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [VALUE_WIDTH-1:0]           value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [dpfc_pkg::COUNT_WIDTH-1:0] factor_count
);

    dpfc_pkg::cmd_t    cmd;
    dpfc_pkg::status_t status;

    dpfc_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dpfc_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .cmd          (cmd),
        .status       (status),
        .factor_count (factor_count)
    );

endmodule

[hw/rtl/dpfc_ctrl.sv]
// ----------------------------------------------------------------------------
// dpfc_ctrl
// Sequencer for trial division: issues load, divide and count commands and
// owns the request handshakes.
// ----------------------------------------------------------------------------
module dpfc_ctrl #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  dpfc_pkg::status_t  status,
    output dpfc_pkg::cmd_t     cmd
);

    localparam int STEP_W = $clog2(VALUE_WIDTH);

    dpfc_pkg::state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              slot_free;

    assign in_ready  = (state_reg == dpfc_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            dpfc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = dpfc_pkg::ST_CHECK;
                end
            end
            dpfc_pkg::ST_CHECK:
            begin
                if (status.search_done)
                begin
                    state_next = dpfc_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    step_next     = STEP_W'(VALUE_WIDTH - 1);
                    state_next    = dpfc_pkg::ST_DIV;
                end
            end
            dpfc_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = dpfc_pkg::ST_TEST;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            dpfc_pkg::ST_TEST:
            begin
                if (status.rem_zero)
                begin
                    // quotient becomes the new dividend, divide again
                    cmd.hit_apply = 1'b1;
                    step_next     = STEP_W'(VALUE_WIDTH - 1);
                    state_next    = dpfc_pkg::ST_DIV;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = dpfc_pkg::ST_CHECK;
                end
            end
            dpfc_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = dpfc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dpfc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dpfc_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hw/rtl/dpfc_datapath.sv]
// ----------------------------------------------------------------------------
// dpfc_datapath
// Remainder, trial divisor, running square, bit-serial restoring divider and
// factor count.
// ----------------------------------------------------------------------------
module dpfc_datapath #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [VALUE_WIDTH-1:0]           value,
    input  dpfc_pkg::cmd_t                   cmd,
    output dpfc_pkg::status_t                status,
    output logic [dpfc_pkg::COUNT_WIDTH-1:0] factor_count
);

    localparam int W    = VALUE_WIDTH;
    // the search ends before the divisor passes sqrt(2^W) + 1
    localparam int DW   = (VALUE_WIDTH + 1) / 2 + 2;
    localparam int SQ_W = VALUE_WIDTH + 2;
    localparam int CW   = dpfc_pkg::COUNT_WIDTH;

    logic [W-1:0]    rem_reg, rem_next;
    logic [DW-1:0]   div_reg, div_next;
    logic [SQ_W-1:0] sq_reg, sq_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            hit_reg, hit_next;
    logic [W-1:0]    quo_reg, quo_next;
    logic [DW-1:0]   part_reg, part_next;
    logic [CW-1:0]   result_reg, result_next;

    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            ge;
    logic            rem_gt1;

    assign trial   = {part_reg, quo_reg[W-1]};
    assign ge      = (trial >= {1'b0, div_reg});
    assign diff    = trial - {1'b0, div_reg};
    assign rem_gt1 = (rem_reg > W'(1));

    assign status.search_done = !rem_gt1 || (sq_reg > SQ_W'(rem_reg));
    assign status.rem_zero    = (part_reg == '0);
    assign factor_count       = result_reg;

    always_comb
    begin
        rem_next    = rem_reg;
        div_next    = div_reg;
        sq_next     = sq_reg;
        cnt_next    = cnt_reg;
        hit_next    = hit_reg;
        quo_next    = quo_reg;
        part_next   = part_reg;
        result_next = result_reg;

        if (cmd.load)
        begin
            rem_next = value;
            div_next = DW'(dpfc_pkg::FIRST_DIVISOR);
            sq_next  = SQ_W'(dpfc_pkg::FIRST_DIVISOR * dpfc_pkg::FIRST_DIVISOR);
            cnt_next = '0;
            hit_next = 1'b0;
        end
        if (cmd.div_start)
        begin
            quo_next  = rem_reg;
            part_next = '0;
        end
        if (cmd.div_step)
        begin
            part_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_next  = {quo_reg[W-2:0], ge};
        end
        if (cmd.hit_apply)
        begin
            // quo_reg already holds the new dividend
            rem_next  = quo_reg;
            part_next = '0;
            hit_next  = 1'b1;
            if (!hit_reg)
            begin
                cnt_next = cnt_reg + CW'(1);
            end
        end
        if (cmd.advance)
        begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_next  = sq_reg + SQ_W'({div_reg, 1'b0}) + SQ_W'(1);
            div_next = div_reg + DW'(1);
            hit_next = 1'b0;
        end
        if (cmd.publish)
        begin
            // leftover cofactor above one is a prime
            result_next = cnt_reg + CW'(rem_gt1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= '0;
            div_reg    <= DW'(dpfc_pkg::FIRST_DIVISOR);
            sq_reg     <= SQ_W'(dpfc_pkg::FIRST_DIVISOR * dpfc_pkg::FIRST_DIVISOR);
            cnt_reg    <= '0;
            hit_reg    <= 1'b0;
            quo_reg    <= '0;
            part_reg   <= '0;
            result_reg <= '0;
        end
        else
        begin
            rem_reg    <= rem_next;
            div_reg    <= div_next;
            sq_reg     <= sq_next;
            cnt_reg    <= cnt_next;
            hit_reg    <= hit_next;
            quo_reg    <= quo_next;
            part_reg   <= part_next;
            result_reg <= result_next;
        end
    end

endmodule

[hw/rtl/dpfc_checker.sv]
// ----------------------------------------------------------------------------
// dpfc_checker
// Port-level checks for the distinct prime factor counter.
// ----------------------------------------------------------------------------
module dpfc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [dpfc_pkg::COUNT_WIDTH-1:0] factor_count
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(factor_count))
        else $error("result dropped or changed while stalled");

    // after a request is taken the block stays busy through the square check and the state that follows it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input taken again too early");

    // a new result only comes out of a busy block
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without work in progress");

    // while idle with no new request, no new result can appear
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !in_valid && (!out_valid || out_ready) |=> !out_valid)
        else $error("result appeared while idle");

endmodule

bind distinct_prime_factor_counter dpfc_checker u_dpfc_checker (.*);

[tb/sv/tb_distinct_prime_factor_counter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distinct_prime_factor_counter
// Self-checking bench for the distinct prime factor counter.
// ----------------------------------------------------------------------------
// Directed values first, a few with hand-written answers, then random values
// biased toward numbers the trial divider finishes quickly. Every accepted
// request without a hand-written answer is scored by a local trial-division
// count. Both handshakes see random backpressure in three phases: light
// sender / heavy receiver, the reverse, then none.
module tb_distinct_prime_factor_counter;

    localparam int          COUNT_W         = dpfc_pkg::COUNT_WIDTH;
    localparam int          CLK_HALF_NS     = 6;
    localparam int          RESET_CYCLES    = 9;
    localparam int          RANDOM_ITEMS    = 80;
    localparam int unsigned RANDOM_COST_CAP = 400;
    localparam int unsigned NO_COST_CAP     = 32'hFFFF_FFF0;
    localparam int          DRAIN_CYCLES    = 140;
    localparam longint      TIMEOUT_NS      = 100_000_000;

    typedef struct packed {
        logic [31:0]        number;
        logic               typed;
        logic [COUNT_W-1:0] count;
    } directed_row_t;

    typedef struct {
        logic [31:0]        number;
        logic [COUNT_W-1:0] count;
    } pending_count_t;

    localparam int DIRECTED_ROWS = 20;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{32'd0,          1'b1, 4'd0},   // zero: no factoring
        '{32'd1,          1'b1, 4'd0},
        '{32'd2,          1'b1, 4'd1},
        '{32'd3,          1'b0, 4'd0},
        '{32'd4,          1'b0, 4'd0},
        '{32'hFFFF_FFFF,  1'b1, 4'd5},   // 3*5*17*257*65537
        '{32'h8000_0000,  1'b1, 4'd1},
        '{32'd223092870,  1'b1, 4'd9},   // primorial of 23, max count
        '{32'h7FFF_FFFE,  1'b0, 4'd0},
        '{32'h5555_5555,  1'b0, 4'd0},
        '{32'hAAAA_AAAA,  1'b0, 4'd0},
        '{32'd65537,      1'b0, 4'd0},   // prime leftover
        '{32'd131042,     1'b0, 4'd0},   // 2 * 65521
        '{32'd4294836225, 1'b0, 4'd0},   // 65535 squared
        '{32'd1024,       1'b0, 4'd0},
        '{32'd30030,      1'b0, 4'd0},
        '{32'd510510,     1'b0, 4'd0},
        '{32'd9699690,    1'b0, 4'd0},
        '{32'd97,         1'b0, 4'd0},
        '{32'd10000,      1'b0, 4'd0}
    };

    localparam int TOTAL_ITEMS = DIRECTED_ROWS + RANDOM_ITEMS;

    localparam int unsigned SMALL_PRIMES [16] = '{
        2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53
    };
    localparam int unsigned LARGE_PRIMES [4] = '{65519, 65521, 65537, 131071};

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [31:0]        value;
    logic               out_valid;
    logic               out_ready;
    logic [COUNT_W-1:0] factor_count;

    pending_count_t pending_counts [$];
    int             mismatches;
    int             send_idle_pct;
    int             recv_idle_pct;

    distinct_prime_factor_counter #(
        .VALUE_WIDTH (32)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .factor_count (factor_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // Trial division; gives up once more than cost_cap divisors and divisions were tried.
    function automatic int unsigned count_distinct_primes(
        input  logic [31:0] number,
        input  int unsigned cost_cap,
        output int unsigned tried
    );
        bit [63:0]   rem;
        bit [63:0]   divisor;
        int unsigned found;
        rem     = number;
        divisor = dpfc_pkg::FIRST_DIVISOR;
        found   = 0;
        tried   = 0;
        if (rem != 0)
        begin
            while (rem > 1 && divisor <= rem / divisor && tried <= cost_cap)
            begin
                tried++;
                if (rem % divisor == 0)
                begin
                    found++;
                    do
                    begin
                        rem = rem / divisor;
                        tried++;
                    end
                    while (rem % divisor == 0);
                end
                divisor++;
            end
            if (rem > 1)
                found++;
        end
        return found;
    endfunction

    // Random value that the divider clears in a bounded number of divisors.
    function automatic logic [31:0] pick_value();
        logic [31:0] cand;
        bit [63:0]   prod;
        int unsigned roll;
        int unsigned cost;
        do
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                cand = 32'($urandom_range(1, 4095)) << $urandom_range(0, 20);
            else if (roll < 50)
            begin
                prod = 1;
                repeat ($urandom_range(1, 8))
                begin
                    roll = SMALL_PRIMES[$urandom_range(0, 15)];
                    if (prod * roll <= 64'hFFFF_FFFF)
                        prod = prod * roll;
                end
                cand = prod[31:0];
            end
            else if (roll < 60)
                cand = 32'($urandom_range(1, 255)) * LARGE_PRIMES[$urandom_range(0, 3)];
            else
                cand = $urandom;
            void'(count_distinct_primes(cand, RANDOM_COST_CAP, cost));
        end
        while (cost > RANDOM_COST_CAP);
        return cand;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns  MISMATCH  %s", $time, msg);
        mismatches++;
    endtask

    initial
    begin : stimulus
        pending_count_t item;
        int unsigned    tried;
        int             phase;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        value         <= '0;
        out_ready     <= 1'b0;
        mismatches    = 0;
        send_idle_pct = 16;
        recv_idle_pct = 63;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int idx = 0; idx < TOTAL_ITEMS; idx++)
        begin
            phase = idx * 3 / TOTAL_ITEMS;
            send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 63 : 0;
            recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 16 : 0;

            if (idx < DIRECTED_ROWS)
                item.number = DIRECTED[idx].number;
            else
                item.number = pick_value();
            if (idx < DIRECTED_ROWS && DIRECTED[idx].typed)
                item.count = DIRECTED[idx].count;
            else
                item.count = COUNT_W'(count_distinct_primes(item.number,
                                                            NO_COST_CAP, tried));

            if ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while ($urandom_range(0, 99) < send_idle_pct);
            end
            in_valid <= 1'b1;
            value    <= item.number;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            pending_counts.push_back(item);
        end
        in_valid <= 1'b0;

        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb_distinct_prime_factor_counter: clean");
        else
            $display("tb_distinct_prime_factor_counter: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : score_results
        pending_count_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (pending_counts.size() == 0)
                report_mismatch($sformatf("unrequested result, factor_count %0d",
                                          factor_count));
            else
            begin
                want = pending_counts.pop_front();
                if (factor_count !== want.count)
                    report_mismatch($sformatf("value %0d: factor_count %0d, want %0d",
                                              want.number, factor_count, want.count));
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_distinct_prime_factor_counter: errors");
        $finish;
    end

endmodule

[files.f]
hw/rtl/dpfc_pkg.sv
hw/rtl/dpfc_ctrl.sv
hw/rtl/dpfc_datapath.sv
hw/rtl/distinct_prime_factor_counter.sv
hw/rtl/dpfc_checker.sv
tb/sv/tb_distinct_prime_factor_counter.sv
